// ===== hdl/flc_pkg.sv =====
// Shared types and constants for the fuzzy lander thrust controller.
// No dependencies; every other file of the block imports this package.
package flc_pkg;

   // Classification of one height membership, worked out by the front end.
   localparam logic [1:0] HK_ZERO  = 2'd0;
   localparam logic [1:0] HK_ONE   = 2'd1;
   localparam logic [1:0] HK_RATIO = 2'd2;

   typedef struct packed {
      logic [1:0] kind;
      logic [8:0] num;   // numerator over 320, 1..319 when kind is ratio
   } hgt_term_type;

   typedef struct packed {
      hgt_term_type low;
      hgt_term_type mid;
      hgt_term_type high;
   } hgt_class_type;

   localparam int HGT_CLASS_BITS = $bits(hgt_class_type);

   // Height slopes divide by 320 = 64 * 5; the divide by five uses
   // floor(2^24 / 5) and a single correction step.
   localparam logic [21:0] DIV5_RECIP = 22'd3355443;
   localparam int          DIV5_SHIFT = 24;

   // Queue between the front and back ends.
   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_BITS   = $clog2(QUEUE_DEPTH);

   // Result codes.
   localparam logic signed [2:0] SIDE_RIGHT = -3'sd2;
   localparam logic signed [2:0] SIDE_NONE  = 3'sd0;
   localparam logic signed [2:0] SIDE_LEFT  = 3'sd2;

   localparam logic [2:0] BURN_NONE = 3'd0;
   localparam logic [2:0] BURN_TIE  = 3'd2;
   localparam logic [2:0] BURN_MED  = 3'd3;
   localparam logic [2:0] BURN_MAX  = 3'd6;

endpackage

// ===== hdl/fuzzy_lander_thrust_controller_unit.sv =====
// Fuzzy lander thrust controller: an item of offset, vertical speed and
// altitude is accepted on every clock while the front queue has room, and its
// result (side thrust, main burn) leaves through the back pipeline. Sustained
// rate is one item per clock while results are not stalled, set by the
// three-stage back pipeline (divide estimate, divide correction, rule
// evaluation); a four-entry queue between the front end and that pipeline
// soaks up result stalls. Nothing is held between items; no set-up is needed.
// Depends on flc_pkg, flc_front, flc_queue and flc_back.
module fuzzy_lander_thrust_controller_unit #(
   parameter int MEMBERSHIP_FRACTION_BITS = 12
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_stall,
   input  logic signed [15:0]  req_x_offset,
   input  logic signed [15:0]  req_vertical_speed,
   input  logic        [15:0]  req_altitude,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output logic signed [2:0]   rsp_side_thrust,
   output logic        [2:0]   rsp_main_burn
);
   import flc_pkg::*;

   localparam int EW = 6 * (MEMBERSHIP_FRACTION_BITS + 1) + HGT_CLASS_BITS;

   logic          push;
   logic          pop;
   logic          queue_full;
   logic          queue_not_empty;
   logic [EW-1:0] wr_entry;
   logic [EW-1:0] rd_entry;

   flc_front #(.B(MEMBERSHIP_FRACTION_BITS)) u_front (
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_x_offset       (req_x_offset),
      .req_vertical_speed (req_vertical_speed),
      .req_altitude       (req_altitude),
      .queue_full         (queue_full),
      .push               (push),
      .entry              (wr_entry)
   );

   flc_queue #(.WIDTH(EW)) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .wr_data   (wr_entry),
      .full      (queue_full),
      .pop       (pop),
      .not_empty (queue_not_empty),
      .rd_data   (rd_entry)
   );

   flc_back #(.B(MEMBERSHIP_FRACTION_BITS)) u_back (
      .clock           (clock),
      .reset           (reset),
      .q_not_empty     (queue_not_empty),
      .q_data          (rd_entry),
      .q_pop           (pop),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_side_thrust (rsp_side_thrust),
      .rsp_main_burn   (rsp_main_burn)
   );

endmodule

// ===== hdl/flc_front.sv =====
// Front end: takes sensor items, fuzzifies offset and speed, classifies height.
// Depends on flc_pkg; feeds flc_queue.
module flc_front #(
   parameter int B = 12
) (
   input  logic                 req_valid,
   output logic                 req_stall,
   input  logic signed [15:0]   req_x_offset,
   input  logic signed [15:0]   req_vertical_speed,
   input  logic        [15:0]   req_altitude,
   input  logic                 queue_full,
   output logic                 push,
   output logic [6*(B+1)+flc_pkg::HGT_CLASS_BITS-1:0] entry
);
   import flc_pkg::*;

   localparam logic [B:0] ONE = {1'b1, {B{1'b0}}};

   logic signed [18:0] a;
   logic signed [18:0] aa;
   logic signed [19:0] v20;
   logic [B:0] x_left, x_mid, x_right;
   logic [B:0] s_low, s_mid, s_high;
   hgt_class_type hcls;

   // num / 2^lg as a membership, clamped to 0..1
   function automatic logic [B:0] ratio_p2(input logic signed [19:0] num, input int lg);
      logic [35:0] t;
      logic [B:0]  r;
      t = '0;
      if (num <= 0) begin
         r = '0;
      end else if (num >= (1 << lg)) begin
         r = ONE;
      end else begin
         t = 36'(unsigned'(num)) << B;
         r = (B+1)'(t >> lg);
      end
      return r;
   endfunction

   assign req_stall = queue_full;
   assign push      = req_valid && !queue_full;

   always_comb begin
      a   = 19'(req_x_offset) * 19'sd5;
      aa  = (a < 0) ? -a : a;
      v20 = 20'(req_vertical_speed);

      x_left  = ratio_p2(20'sd0 - 20'(a), 12);
      x_mid   = ratio_p2(20'sd4096 - 20'(aa), 12);
      x_right = ratio_p2(20'(a), 12);

      s_low = (req_vertical_speed < 16'sd512) ? ONE : ratio_p2(20'sd1024 - v20, 9);
      if (req_vertical_speed >= 16'sd768 && req_vertical_speed <= 16'sd1280) begin
         s_mid = ratio_p2(v20 - 20'sd768, 9);
      end else if (req_vertical_speed > 16'sd1280 && req_vertical_speed <= 16'sd1792) begin
         s_mid = ratio_p2(20'sd1792 - v20, 9);
      end else begin
         s_mid = '0;
      end
      s_high = ratio_p2(v20 - 20'sd1536, 9);

      // height: every slope is over 320, so only the numerator travels on
      hcls = '0;
      if (req_altitude <= 16'd320) begin
         hcls.low.kind = HK_ONE;
      end else if (req_altitude >= 16'd640) begin
         hcls.low.kind = HK_ZERO;
      end else begin
         hcls.low.kind = HK_RATIO;
         hcls.low.num  = 9'(16'd640 - req_altitude);
      end

      if (req_altitude > 16'd480 && req_altitude < 16'd800) begin
         hcls.mid.kind = HK_RATIO;
         hcls.mid.num  = 9'(req_altitude - 16'd480);
      end else if (req_altitude == 16'd800) begin
         hcls.mid.kind = HK_ONE;
      end else if (req_altitude > 16'd800 && req_altitude < 16'd1120) begin
         hcls.mid.kind = HK_RATIO;
         hcls.mid.num  = 9'(16'd1120 - req_altitude);
      end else begin
         hcls.mid.kind = HK_ZERO;
      end

      if (req_altitude >= 16'd1280) begin
         hcls.high.kind = HK_ONE;
      end else if (req_altitude <= 16'd960) begin
         hcls.high.kind = HK_ZERO;
      end else begin
         hcls.high.kind = HK_RATIO;
         hcls.high.num  = 9'(req_altitude - 16'd960);
      end
   end

   assign entry = {x_left, x_mid, x_right, s_low, s_mid, s_high, hcls};

endmodule

// ===== hdl/flc_queue.sv =====
// Short FIFO that decouples the front end from the back-end pipeline.
// Depends on flc_pkg for its depth.
module flc_queue #(
   parameter int WIDTH = 111
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] wr_data,
   output logic             full,
   input  logic             pop,
   output logic             not_empty,
   output logic [WIDTH-1:0] rd_data
);
   import flc_pkg::*;

   logic [WIDTH-1:0]     mem_ff [QUEUE_DEPTH];
   logic [QPTR_BITS-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QPTR_BITS-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QPTR_BITS:0]   cnt_ff, cnt_in;

   assign full      = (cnt_ff == (QPTR_BITS+1)'(QUEUE_DEPTH));
   assign not_empty = (cnt_ff != '0);
   assign rd_data   = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? QPTR_BITS'(wr_ptr_ff + 1'b1) : wr_ptr_ff;
      rd_ptr_in = pop  ? QPTR_BITS'(rd_ptr_ff + 1'b1) : rd_ptr_ff;
      cnt_in    = cnt_ff;
      if (push && !pop) begin
         cnt_in = cnt_ff + 1'b1;
      end else if (pop && !push) begin
         cnt_in = cnt_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         cnt_ff    <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= wr_data;
      end
   end

   a_cnt_bound: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= (QPTR_BITS+1)'(QUEUE_DEPTH))
      else $error("queue fill count beyond depth");

   a_no_underflow: assert property (@(posedge clock) disable iff (reset)
      pop |-> cnt_ff != '0)
      else $error("pop from empty queue");

endmodule

// ===== hdl/flc_back.sv =====
// Back end: finishes the height divide, fires min-max rules, picks the outputs.
// Depends on flc_pkg; takes items from flc_queue.
module flc_back #(
   parameter int B = 12
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  q_not_empty,
   input  logic [6*(B+1)+flc_pkg::HGT_CLASS_BITS-1:0] q_data,
   output logic                  q_pop,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output logic signed [2:0]     rsp_side_thrust,
   output logic        [2:0]     rsp_main_burn
);
   import flc_pkg::*;

   localparam int QW = B + 3;              // (num << B) >> 6 with num < 320
   localparam int PW = QW + 22;
   localparam logic [B:0] ONE = {1'b1, {B{1'b0}}};

   // queue entry fields
   logic [B:0]    e_xl, e_xm, e_xr, e_sl, e_sm, e_sh;
   hgt_class_type e_h;
   logic [1:0]    e_kind [3];
   logic [8:0]    e_num  [3];

   // stage 1: quotient estimate
   logic          s1_valid_ff, s1_valid_in;
   logic [B:0]    s1_x_ff [3];
   logic [B:0]    s1_s_ff [3];
   logic [1:0]    s1_kind_ff [3], s1_kind_in [3];
   logic [QW-1:0] s1_q_ff [3], s1_q_in [3];
   logic [B:0]    s1_est_ff [3], s1_est_in [3];
   logic          s1_ready;

   // stage 2: memberships
   logic          s2_valid_ff, s2_valid_in;
   logic [B:0]    s2_x_ff [3];
   logic [B:0]    s2_s_ff [3];
   logic [B:0]    s2_h_ff [3], s2_h_in [3];
   logic          s2_ready;

   // result register
   logic              rsp_valid_ff, rsp_valid_in;
   logic signed [2:0] side_ff, side_in;
   logic [2:0]        burn_ff, burn_in;
   logic              out_ready;

   function automatic logic [B:0] mn(input logic [B:0] p, input logic [B:0] q);
      return (p < q) ? p : q;
   endfunction

   function automatic logic [B:0] mx(input logic [B:0] p, input logic [B:0] q);
      return (p > q) ? p : q;
   endfunction

   assign {e_xl, e_xm, e_xr, e_sl, e_sm, e_sh, e_h} = q_data;

   assign out_ready = !rsp_valid_ff || !rsp_stall;
   assign s2_ready  = !s2_valid_ff || out_ready;
   assign s1_ready  = !s1_valid_ff || s2_ready;
   assign q_pop     = q_not_empty && s1_ready;

   // stage 1: q = num * 2^B / 64, then q / 5 by reciprocal (may be one short)
   always_comb begin
      logic [B+8:0] sh;
      logic [PW-1:0] prod;
      e_kind[0] = e_h.low.kind;
      e_kind[1] = e_h.mid.kind;
      e_kind[2] = e_h.high.kind;
      e_num[0]  = e_h.low.num;
      e_num[1]  = e_h.mid.num;
      e_num[2]  = e_h.high.num;
      for (int i = 0; i < 3; i++) begin
         sh            = (B+9)'(e_num[i]) << B;
         s1_q_in[i]    = sh[B+8:6];
         prod          = PW'(s1_q_in[i]) * PW'(DIV5_RECIP);
         s1_est_in[i]  = prod[DIV5_SHIFT+B:DIV5_SHIFT];
         s1_kind_in[i] = e_kind[i];
      end
      s1_valid_in = s1_ready ? q_not_empty : s1_valid_ff;
   end

   // stage 2: correct the estimate and resolve the height memberships
   always_comb begin
      logic [QW-1:0] rem;
      for (int i = 0; i < 3; i++) begin
         rem = s1_q_ff[i] - (QW'(s1_est_ff[i]) << 2) - QW'(s1_est_ff[i]);
         case (s1_kind_ff[i])
            HK_ONE:   s2_h_in[i] = ONE;
            HK_RATIO: s2_h_in[i] = (rem >= QW'(5)) ? s1_est_ff[i] + 1'b1 : s1_est_ff[i];
            default:  s2_h_in[i] = '0;
         endcase
      end
      s2_valid_in = s2_ready ? s1_valid_ff : s2_valid_ff;
   end

   // stage 3: rules and decision; index 0 low / left, 1 mid, 2 high / right
   always_comb begin
      logic [B:0] hmax, r_right, r_none, r_left, b_none, b_med, b_max;
      hmax    = mx(mx(s2_h_ff[2], s2_h_ff[1]), s2_h_ff[0]);
      r_right = mn(s2_x_ff[0], hmax);
      r_none  = mn(s2_x_ff[1], hmax);
      r_left  = mn(s2_x_ff[2], hmax);

      b_max = mn(s2_h_ff[0], s2_s_ff[2]);
      b_med = mn(s2_h_ff[0], s2_s_ff[1]);
      b_med = mx(b_med, mn(s2_h_ff[0], s2_s_ff[0]));
      b_med = mx(b_med, mn(s2_h_ff[1], s2_s_ff[2]));
      b_med = mx(b_med, mn(s2_h_ff[1], s2_s_ff[1]));
      b_med = mx(b_med, mn(s2_h_ff[1], s2_s_ff[0]));
      b_med = mx(b_med, mn(s2_h_ff[2], s2_s_ff[2]));
      b_med = mx(b_med, mn(s2_h_ff[2], s2_s_ff[1]));
      b_none = mn(s2_h_ff[2], s2_s_ff[0]);

      if (r_none > r_left && r_none > r_right) begin
         side_in = SIDE_NONE;
      end else if (r_right > r_none && r_right > r_left) begin
         side_in = SIDE_RIGHT;
      end else if (r_left > r_none && r_left > r_right) begin
         side_in = SIDE_LEFT;
      end else begin
         side_in = SIDE_NONE;
      end

      if (b_none > b_med && b_none > b_max) begin
         burn_in = BURN_NONE;
      end else if (b_med > b_none && b_med > b_max) begin
         burn_in = BURN_MED;
      end else if (b_max > b_none && b_max > b_med) begin
         burn_in = BURN_MAX;
      end else begin
         burn_in = BURN_TIE;
      end

      rsp_valid_in = out_ready ? s2_valid_ff : rsp_valid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         s2_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         s2_valid_ff  <= s2_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_ready) begin
         s1_x_ff[0] <= e_xl;
         s1_x_ff[1] <= e_xm;
         s1_x_ff[2] <= e_xr;
         s1_s_ff[0] <= e_sl;
         s1_s_ff[1] <= e_sm;
         s1_s_ff[2] <= e_sh;
         s1_kind_ff <= s1_kind_in;
         s1_q_ff    <= s1_q_in;
         s1_est_ff  <= s1_est_in;
      end
      if (s2_ready) begin
         s2_x_ff <= s1_x_ff;
         s2_s_ff <= s1_s_ff;
         s2_h_ff <= s2_h_in;
      end
      if (out_ready) begin
         side_ff <= side_in;
         burn_ff <= burn_in;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_side_thrust = side_ff;
   assign rsp_main_burn   = burn_ff;

   a_side_code: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (side_ff == SIDE_RIGHT || side_ff == SIDE_NONE || side_ff == SIDE_LEFT))
      else $error("illegal side thrust code");

   a_burn_code: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (burn_ff == BURN_NONE || burn_ff == BURN_TIE ||
                        burn_ff == BURN_MED || burn_ff == BURN_MAX))
      else $error("illegal main burn code");

   a_height_bound: assert property (@(posedge clock) disable iff (reset)
      s2_valid_ff |-> (s2_h_ff[0] <= ONE && s2_h_ff[1] <= ONE && s2_h_ff[2] <= ONE))
      else $error("height membership above one after divide correction");

endmodule

// ===== bench/fuzzy_lander_thrust_controller_unit_tb.sv =====
// Self-checking bench for the fuzzy lander thrust controller: directed table,
// then random sample sets, results compared with a built-in min-max predictor
// or the typed table expectations. Depends on flc_pkg and fuzzy_lander_thrust_controller_unit.
`timescale 1ns / 1ps

module fuzzy_lander_thrust_controller_unit_tb;
   import flc_pkg::*;

   localparam int GRADE_BITS  = 12;
   localparam int GRADE_ONE   = 1 << GRADE_BITS;
   localparam int HOLD_CYCLES = 64;
   localparam int STUCK_LIMIT = 4000;
   localparam int SETTLE      = 12;
   localparam int NUM_PROBES  = 24;

   typedef struct {
      logic signed [2:0] side;
      logic        [2:0] burn;
   } thrust_cmd_t;

   typedef struct {
      logic signed [15:0] x;
      logic signed [15:0] v;
      logic        [15:0] h;
      bit                 typed;
      logic signed [2:0]  side;
      logic        [2:0]  burn;
   } probe_row_t;

   logic               clock;
   logic               reset;
   logic               req_valid;
   logic               req_stall;
   logic signed [15:0] req_x_offset;
   logic signed [15:0] req_vertical_speed;
   logic        [15:0] req_altitude;
   logic               rsp_valid;
   logic               rsp_stall;
   logic signed [2:0]  rsp_side_thrust;
   logic        [2:0]  rsp_main_burn;

   thrust_cmd_t pending_cmds[$];
   int          mismatches;
   int          stuck_cycles;
   bit          calm;
   bit          burst;
   bit          hold_req;
   int          hold_left;

   // Typed expectations only where they are obvious; the rest go to the predictor.
   probe_row_t probe_rows[NUM_PROBES] = '{
      '{16'sd0,      16'sd0,      16'd0,     1'b1, SIDE_NONE,  BURN_MED},
      '{16'sh8000,   16'sh7fff,   16'd0,     1'b1, SIDE_RIGHT, BURN_MAX},
      '{16'sh7fff,   16'sh8000,   16'hffff,  1'b1, SIDE_LEFT,  BURN_NONE},
      '{16'sd0,      16'sd1664,   16'd0,     1'b1, SIDE_NONE,  BURN_TIE},
      '{16'sd0,      16'sd0,      16'hffff,  1'b1, SIDE_NONE,  BURN_NONE},
      '{16'sd0,      16'sh7fff,   16'hffff,  1'b1, SIDE_NONE,  BURN_MED},
      '{-16'sd492,   16'sd0,      16'd560,   1'b0, SIDE_NONE,  BURN_NONE},
      '{-16'sd819,   16'sd511,    16'd320,   1'b0, SIDE_NONE,  BURN_NONE},
      '{-16'sd820,   16'sd512,    16'd321,   1'b0, SIDE_NONE,  BURN_NONE},
      '{16'sd819,    16'sd768,    16'd480,   1'b0, SIDE_NONE,  BURN_NONE},
      '{16'sd820,    16'sd1280,   16'd640,   1'b0, SIDE_NONE,  BURN_NONE},
      '{16'sd1,      16'sd1281,   16'd800,   1'b0, SIDE_NONE,  BURN_NONE},
      '{-16'sd1,     16'sd1536,   16'd801,   1'b0, SIDE_NONE,  BURN_NONE},
      '{16'sd410,    16'sd1792,   16'd960,   1'b0, SIDE_NONE,  BURN_NONE},
      '{-16'sd410,   16'sd2047,   16'd1120,  1'b0, SIDE_NONE,  BURN_NONE},
      '{16'sd2048,   16'sd2048,   16'd1280,  1'b0, SIDE_NONE,  BURN_NONE},
      '{-16'sd2048,  -16'sd1,     16'd1281,  1'b0, SIDE_NONE,  BURN_NONE},
      '{16'sd100,    16'sh8000,   16'd1600,  1'b0, SIDE_NONE,  BURN_NONE},
      '{16'sd0,      16'sd1000,   16'd1601,  1'b0, SIDE_NONE,  BURN_NONE},
      '{16'sd300,    16'sd700,    16'd700,   1'b0, SIDE_NONE,  BURN_NONE},
      '{-16'sd300,   16'sd1400,   16'd1000,  1'b0, SIDE_NONE,  BURN_NONE},
      '{16'sd21845,  16'sd21845,  16'haaaa,  1'b0, SIDE_NONE,  BURN_NONE},
      '{-16'sd21846, -16'sd21846, 16'h5555,  1'b0, SIDE_NONE,  BURN_NONE},
      '{16'sd5,      16'sd1664,   16'd560,   1'b0, SIDE_NONE,  BURN_NONE}
   };

   fuzzy_lander_thrust_controller_unit #(
      .MEMBERSHIP_FRACTION_BITS(GRADE_BITS)
   ) dut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_x_offset      (req_x_offset),
      .req_vertical_speed(req_vertical_speed),
      .req_altitude      (req_altitude),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_side_thrust   (rsp_side_thrust),
      .rsp_main_burn     (rsp_main_burn)
   );

   initial clock = 1'b0;
   always #4 clock = ~clock;

   // Membership on a sloped segment: num / den, truncated, clipped to 0..1.
   function automatic int grade(int num, int den);
      if (num <= 0) return 0;
      if (num >= den) return GRADE_ONE;
      return int'((longint'(num) << GRADE_BITS) / den);
   endfunction

   function automatic int lesser(int a, int b);
      return (a < b) ? a : b;
   endfunction

   function automatic int greater(int a, int b);
      return (a > b) ? a : b;
   endfunction

   function automatic thrust_cmd_t lander_command(logic signed [15:0] x,
                                                  logic signed [15:0] v,
                                                  logic [15:0] h);
      int xr, vr, hr, a, aa;
      int x_left, x_mid, x_right, s_low, s_mid, s_high;
      int h_low, h_mid, h_high, h_any;
      int r_right, r_none, r_left, b_none, b_med, b_max;
      thrust_cmd_t cmd;
      xr = x;
      vr = v;
      hr = h;
      a  = 5 * xr;
      aa = (a < 0) ? -a : a;

      x_left  = grade(-a, 4096);
      x_mid   = grade(4096 - aa, 4096);
      x_right = grade(a, 4096);

      s_low = (vr < 512) ? GRADE_ONE : grade(1024 - vr, 512);
      if (vr >= 768 && vr <= 1280) s_mid = grade(vr - 768, 512);
      else if (vr > 1280 && vr <= 1792) s_mid = grade(1792 - vr, 512);
      else s_mid = 0;
      s_high = grade(vr - 1536, 512);

      h_low = (hr <= 320) ? GRADE_ONE : grade(640 - hr, 320);
      if (hr >= 480 && hr <= 800) h_mid = grade(hr - 480, 320);
      else if (hr > 800 && hr <= 1120) h_mid = grade(1120 - hr, 320);
      else h_mid = 0;
      h_high = (hr > 1280) ? GRADE_ONE : grade(hr - 960, 320);

      // every side rule pairs an offset level with each height level
      h_any   = greater(greater(h_low, h_mid), h_high);
      r_right = lesser(x_left, h_any);
      r_none  = lesser(x_mid, h_any);
      r_left  = lesser(x_right, h_any);

      b_max  = lesser(h_low, s_high);
      b_none = lesser(h_high, s_low);
      b_med  = greater(lesser(h_low, s_mid), lesser(h_low, s_low));
      b_med  = greater(b_med, lesser(h_mid, greater(greater(s_low, s_mid), s_high)));
      b_med  = greater(b_med, lesser(h_high, greater(s_mid, s_high)));

      if (r_none > r_left && r_none > r_right) cmd.side = SIDE_NONE;
      else if (r_right > r_none && r_right > r_left) cmd.side = SIDE_RIGHT;
      else if (r_left > r_none && r_left > r_right) cmd.side = SIDE_LEFT;
      else cmd.side = SIDE_NONE;

      if (b_none > b_med && b_none > b_max) cmd.burn = BURN_NONE;
      else if (b_med > b_none && b_med > b_max) cmd.burn = BURN_MED;
      else if (b_max > b_none && b_max > b_med) cmd.burn = BURN_MAX;
      else cmd.burn = BURN_TIE;
      return cmd;
   endfunction

   task automatic note_mismatch(string what);
      mismatches++;
      if (mismatches <= 10) $display("%0t: %s", $realtime, what);
   endtask

   // Called at a falling edge; returns at the falling edge after acceptance.
   task automatic offer_item(logic signed [15:0] x, logic signed [15:0] v,
                             logic [15:0] h, bit typed, thrust_cmd_t given);
      if (!calm && !burst) begin
         while ($urandom_range(99) < 35) begin
            req_valid <= 1'b0;
            @(negedge clock);
         end
      end
      req_valid          <= 1'b1;
      req_x_offset       <= x;
      req_vertical_speed <= v;
      req_altitude       <= h;
      do @(posedge clock); while (req_stall);
      pending_cmds.push_back(typed ? given : lander_command(x, v, h));
      @(negedge clock);
   endtask

   task automatic offer_random(int count);
      logic signed [15:0] x, v;
      logic [15:0] h;
      thrust_cmd_t none;
      none.side = SIDE_NONE;
      none.burn = BURN_NONE;
      repeat (count) begin
         if ($urandom_range(99) < 80) begin
            // keep most samples near the breakpoints where the rules interact
            x = 16'(int'($urandom_range(2600)) - 1300);
            v = 16'(int'($urandom_range(3000)) - 600);
            h = 16'($urandom_range(1900));
         end else begin
            x = 16'($urandom);
            v = 16'($urandom);
            h = 16'($urandom);
         end
         offer_item(x, v, h, 1'b0, none);
      end
   endtask

   task automatic drain_results;
      while (pending_cmds.size() != 0) @(negedge clock);
   endtask

   // Result side: random stall unless calm, with an occasional long hold-off on request.
   initial begin
      rsp_stall = 1'b0;
      hold_left = 0;
      forever begin
         @(negedge clock);
         if (hold_left > 0) begin
            rsp_stall <= 1'b1;
            hold_left--;
         end else if (hold_req) begin
            hold_req  = 1'b0;
            hold_left = HOLD_CYCLES;
            rsp_stall <= 1'b1;
         end else begin
            rsp_stall <= !calm && ($urandom_range(99) < 35);
         end
      end
   end

   // Result checker and stuck-run watchdog.
   always @(posedge clock) begin
      thrust_cmd_t want;
      if (reset) begin
         stuck_cycles <= 0;
      end else begin
         if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) stuck_cycles <= 0;
         else stuck_cycles <= stuck_cycles + 1;
         if (rsp_valid && !rsp_stall) begin
            if (pending_cmds.size() == 0) begin
               note_mismatch($sformatf("unexpected result side=%0d burn=%0d",
                                       rsp_side_thrust, rsp_main_burn));
            end else begin
               want = pending_cmds.pop_front();
               if (rsp_side_thrust !== want.side)
                  note_mismatch($sformatf("side_thrust expected %0d got %0d",
                                          want.side, rsp_side_thrust));
               if (rsp_main_burn !== want.burn)
                  note_mismatch($sformatf("main_burn expected %0d got %0d",
                                          want.burn, rsp_main_burn));
            end
         end
         if (stuck_cycles >= STUCK_LIMIT) begin
            $display("fuzzy_lander_thrust_controller_unit: mismatch");
            $finish;
         end
      end
   end

   initial begin
      thrust_cmd_t given;
      mismatches         = 0;
      calm               = 1'b0;
      burst              = 1'b0;
      hold_req           = 1'b0;
      reset              = 1'b1;
      req_valid          = 1'b0;
      req_x_offset       = '0;
      req_vertical_speed = '0;
      req_altitude       = '0;
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      foreach (probe_rows[i]) begin
         given.side = probe_rows[i].side;
         given.burn = probe_rows[i].burn;
         offer_item(probe_rows[i].x, probe_rows[i].v, probe_rows[i].h,
                    probe_rows[i].typed, given);
      end
      req_valid <= 1'b0;
      drain_results();

      offer_random(600);

      // long result hold-off while items keep coming, so the input backs up
      burst    = 1'b1;
      hold_req = 1'b1;
      offer_random(40);
      burst    = 1'b0;
      req_valid <= 1'b0;
      drain_results();

      calm = 1'b1;
      offer_random(400);
      calm = 1'b0;

      offer_random(886);
      req_valid <= 1'b0;
      drain_results();
      repeat (SETTLE) @(posedge clock);

      if (mismatches == 0 && pending_cmds.size() == 0)
         $display("fuzzy_lander_thrust_controller_unit: match");
      else
         $display("fuzzy_lander_thrust_controller_unit: mismatch");
      $finish;
   end

endmodule

// ===== sim.f =====
hdl/flc_pkg.sv
hdl/flc_front.sv
hdl/flc_queue.sv
hdl/flc_back.sv
hdl/fuzzy_lander_thrust_controller_unit.sv
bench/fuzzy_lander_thrust_controller_unit_tb.sv
